@@ design/tch_pkg.sv @@
// shared types, constants and the arctangent table for the heading pipeline
package tch_pkg;

  localparam int AtanLen  = 24;  // arctangent table length, also the stage cap
  localparam int ZW       = 20;  // angle width, q16 radians
  localparam int SqW      = 32;  // sum of two squares
  localparam int RootW    = 30;  // square root result, q14
  localparam int RemW     = 34;  // square root partial remainder
  localparam int SqCells  = 30;  // one result bit per cell
  localparam int TW       = 34;  // tilt vectoring datapath
  localparam int RW       = 20;  // unit rotation datapath
  localparam int HW       = 56;  // horizontal field components, q32
  localparam int AW       = 58;  // heading vectoring datapath
  localparam int ProdW    = 49;  // angle times scale factor

  localparam logic signed [ZW-1:0] InvGain = 20'sd39797;
  localparam logic signed [ZW-1:0] HalfPi  = 20'sd102944;
  localparam logic [28:0]          Deg100PerRad = 29'd375493621;
  localparam logic [17:0]          MaxDeg100    = 18'd18000;

  typedef struct packed {
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] mz;
    logic               azero;
  } tch_side_t;

  // round(atan(2^-i) * 2^16)
  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = 20'sd51472;
      1:       v = 20'sd30385;
      2:       v = 20'sd16055;
      3:       v = 20'sd8150;
      4:       v = 20'sd4091;
      5:       v = 20'sd2047;
      6:       v = 20'sd1024;
      7:       v = 20'sd512;
      8:       v = 20'sd256;
      9:       v = 20'sd128;
      10:      v = 20'sd64;
      11:      v = 20'sd32;
      12:      v = 20'sd16;
      13:      v = 20'sd8;
      14:      v = 20'sd4;
      15:      v = 20'sd2;
      16:      v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ design/tch_sqrt_cell.sv @@
// one bit of a restoring square root, two radicand bits consumed per cell
module tch_sqrt_cell (
  input  logic                           clk,
  input  logic                           en,
  input  logic [tch_pkg::SqW-1:0]        rad_i,
  input  logic [tch_pkg::RemW-1:0]       rem_i,
  input  logic [tch_pkg::RootW-1:0]      root_i,
  output logic [tch_pkg::SqW-1:0]        rad_o,
  output logic [tch_pkg::RemW-1:0]       rem_o,
  output logic [tch_pkg::RootW-1:0]      root_o
);

  logic [tch_pkg::RemW-1:0] trial;
  logic [tch_pkg::RemW-1:0] test;

  assign trial = {rem_i[tch_pkg::RemW-3:0], rad_i[tch_pkg::SqW-1 -: 2]};
  assign test  = {2'b00, root_i, 2'b01};

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o <= {rad_i[tch_pkg::SqW-3:0], 2'b00};
      if (trial >= test) begin
        rem_o  <= trial - test;
        root_o <= {root_i[tch_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_o  <= trial;
        root_o <= {root_i[tch_pkg::RootW-2:0], 1'b0};
      end
    end
  end

endmodule

@@ design/tch_vec_cell.sv @@
// one vectoring cordic micro-rotation, drives y toward zero
module tch_vec_cell #(
  parameter int W  = 34,
  parameter int SH = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [W-1:0]           x_i,
  input  logic signed [W-1:0]           y_i,
  input  logic signed [tch_pkg::ZW-1:0] z_i,
  output logic signed [W-1:0]           x_o,
  output logic signed [W-1:0]           y_o,
  output logic signed [tch_pkg::ZW-1:0] z_o
);

  logic signed [W-1:0] xs;
  logic signed [W-1:0] ys;

  assign xs = x_i >>> SH;
  assign ys = y_i >>> SH;

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_i < 0) begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - tch_pkg::atan_q16(SH);
      end else begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + tch_pkg::atan_q16(SH);
      end
    end
  end

endmodule

@@ design/tch_rot_cell.sv @@
// one rotation cordic micro-rotation, drives z toward zero
module tch_rot_cell #(
  parameter int SH = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [tch_pkg::RW-1:0] x_i,
  input  logic signed [tch_pkg::RW-1:0] y_i,
  input  logic signed [tch_pkg::ZW-1:0] z_i,
  output logic signed [tch_pkg::RW-1:0] x_o,
  output logic signed [tch_pkg::RW-1:0] y_o,
  output logic signed [tch_pkg::ZW-1:0] z_o
);

  logic signed [tch_pkg::RW-1:0] xs;
  logic signed [tch_pkg::RW-1:0] ys;

  assign xs = x_i >>> SH;
  assign ys = y_i >>> SH;

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_i >= 0) begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - tch_pkg::atan_q16(SH);
      end else begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + tch_pkg::atan_q16(SH);
      end
    end
  end

endmodule

@@ design/tilt_compensated_heading.sv @@
// top level of the tilt-compensated compass heading pipeline
// Takes one accelerometer and magnetometer sample per request and returns the
// heading atan2(hy, hx) in signed hundredths of a degree, -18000..18000 (not
// wrapped to 0..36000). The block is a fully pipelined chain of cells and
// accepts one request every clock cycle while in_stall is low. In order, with N the
// cordic stage count (CORDIC_STAGES, capped at 24), it holds a squaring register, a
// 30-cell square root chain, N vectoring cells for pitch and roll, N rotation
// cells for their sines and cosines, three multiply stages, N vectoring cells
// for the heading, one scaling multiply and the output register. A stalled
// result freezes the whole pipeline; input stall is high only while the
// output register holds a result that is not being taken. All-zero
// acceleration gives zero tilt, and a zero horizontal field gives heading 0.
module tilt_compensated_heading #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_mag_x,
  input  logic signed [15:0] in_mag_y,
  input  logic signed [15:0] in_mag_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_heading
);

  localparam int N   = (CORDIC_STAGES > tch_pkg::AtanLen) ? tch_pkg::AtanLen : CORDIC_STAGES;
  localparam int Lat = 36 + 3 * N;
  localparam int Sq  = tch_pkg::SqCells;

  // global advance: the pipeline moves unless a finished result is held
  logic           adv;
  logic [Lat-1:0] vld_r;

  assign adv       = !(vld_r[Lat-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[Lat-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Lat-2:0], in_valid};
    end
  end

  // squares, summed wide
  logic signed [31:0] sq_xx, sq_yy, sq_zz;
  logic [tch_pkg::SqW-1:0] sq_yz_r, sq_xz_r;
  logic signed [15:0]      sq_ax_r, sq_ay_r;
  tch_pkg::tch_side_t      sq_side_r;

  assign sq_xx = in_accel_x * in_accel_x;
  assign sq_yy = in_accel_y * in_accel_y;
  assign sq_zz = in_accel_z * in_accel_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_yz_r         <= unsigned'(sq_yy) + unsigned'(sq_zz);
      sq_xz_r         <= unsigned'(sq_xx) + unsigned'(sq_zz);
      sq_ax_r         <= in_accel_x;
      sq_ay_r         <= in_accel_y;
      sq_side_r.mx    <= in_mag_x;
      sq_side_r.my    <= in_mag_y;
      sq_side_r.mz    <= in_mag_z;
      sq_side_r.azero <= (in_accel_x == 16'sd0) && (in_accel_y == 16'sd0) &&
                         (in_accel_z == 16'sd0);
    end
  end

  // square root chains, sqrt(s * 2^28) in q14
  logic [tch_pkg::SqW-1:0]   ryz [0:Sq];
  logic [tch_pkg::RemW-1:0]  myz [0:Sq];
  logic [tch_pkg::RootW-1:0] qyz [0:Sq];
  logic [tch_pkg::SqW-1:0]   rxz [0:Sq];
  logic [tch_pkg::RemW-1:0]  mxz [0:Sq];
  logic [tch_pkg::RootW-1:0] qxz [0:Sq];
  logic signed [15:0]        sqd_ax [0:Sq];
  logic signed [15:0]        sqd_ay [0:Sq];
  tch_pkg::tch_side_t        sqd_side [0:Sq];

  assign ryz[0]      = sq_yz_r;
  assign myz[0]      = '0;
  assign qyz[0]      = '0;
  assign rxz[0]      = sq_xz_r;
  assign mxz[0]      = '0;
  assign qxz[0]      = '0;
  assign sqd_ax[0]   = sq_ax_r;
  assign sqd_ay[0]   = sq_ay_r;
  assign sqd_side[0] = sq_side_r;

  for (genvar k = 0; k < Sq; k++) begin : g_sqrt
    tch_sqrt_cell u_yz (
      .clk(clk), .en(adv),
      .rad_i(ryz[k]), .rem_i(myz[k]), .root_i(qyz[k]),
      .rad_o(ryz[k+1]), .rem_o(myz[k+1]), .root_o(qyz[k+1])
    );
    tch_sqrt_cell u_xz (
      .clk(clk), .en(adv),
      .rad_i(rxz[k]), .rem_i(mxz[k]), .root_i(qxz[k]),
      .rad_o(rxz[k+1]), .rem_o(mxz[k+1]), .root_o(qxz[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        sqd_ax[k+1]   <= sqd_ax[k];
        sqd_ay[k+1]   <= sqd_ay[k];
        sqd_side[k+1] <= sqd_side[k];
      end
    end
  end

  // pitch and roll vectoring
  logic signed [tch_pkg::TW-1:0] px [0:N];
  logic signed [tch_pkg::TW-1:0] py [0:N];
  logic signed [tch_pkg::ZW-1:0] pz [0:N];
  logic signed [tch_pkg::TW-1:0] lx [0:N];
  logic signed [tch_pkg::TW-1:0] ly [0:N];
  logic signed [tch_pkg::ZW-1:0] lz [0:N];
  tch_pkg::tch_side_t            vd_side [0:N];

  assign px[0] = signed'({4'b0000, qyz[Sq]});
  assign py[0] = {{4{sqd_ax[Sq][15]}}, sqd_ax[Sq], 14'b0};
  assign pz[0] = '0;
  assign lx[0] = signed'({4'b0000, qxz[Sq]});
  assign ly[0] = {{4{sqd_ay[Sq][15]}}, sqd_ay[Sq], 14'b0};
  assign lz[0] = '0;
  assign vd_side[0] = sqd_side[Sq];

  for (genvar k = 0; k < N; k++) begin : g_tilt
    tch_vec_cell #(.W(tch_pkg::TW), .SH(k)) u_pitch (
      .clk(clk), .en(adv),
      .x_i(px[k]), .y_i(py[k]), .z_i(pz[k]),
      .x_o(px[k+1]), .y_o(py[k+1]), .z_o(pz[k+1])
    );
    tch_vec_cell #(.W(tch_pkg::TW), .SH(k)) u_roll (
      .clk(clk), .en(adv),
      .x_i(lx[k]), .y_i(ly[k]), .z_i(lz[k]),
      .x_o(lx[k+1]), .y_o(ly[k+1]), .z_o(lz[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        vd_side[k+1] <= vd_side[k];
      end
    end
  end

  // sine and cosine of pitch and roll, zero acceleration means zero tilt
  logic signed [tch_pkg::RW-1:0] cpx [0:N];
  logic signed [tch_pkg::RW-1:0] cpy [0:N];
  logic signed [tch_pkg::ZW-1:0] cpz [0:N];
  logic signed [tch_pkg::RW-1:0] crx [0:N];
  logic signed [tch_pkg::RW-1:0] cry [0:N];
  logic signed [tch_pkg::ZW-1:0] crz [0:N];
  tch_pkg::tch_side_t            rd_side [0:N];

  assign cpx[0] = tch_pkg::InvGain;
  assign cpy[0] = '0;
  assign cpz[0] = vd_side[N].azero ? '0 : pz[N];
  assign crx[0] = tch_pkg::InvGain;
  assign cry[0] = '0;
  assign crz[0] = vd_side[N].azero ? '0 : lz[N];
  assign rd_side[0] = vd_side[N];

  for (genvar k = 0; k < N; k++) begin : g_rot
    tch_rot_cell #(.SH(k)) u_pitch (
      .clk(clk), .en(adv),
      .x_i(cpx[k]), .y_i(cpy[k]), .z_i(cpz[k]),
      .x_o(cpx[k+1]), .y_o(cpy[k+1]), .z_o(cpz[k+1])
    );
    tch_rot_cell #(.SH(k)) u_roll (
      .clk(clk), .en(adv),
      .x_i(crx[k]), .y_i(cry[k]), .z_i(crz[k]),
      .x_o(crx[k+1]), .y_o(cry[k+1]), .z_o(crz[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        rd_side[k+1] <= rd_side[k];
      end
    end
  end

  // magnetic vector back to the horizontal plane
  logic signed [35:0]             m1_mxcp_r, m1_mzsp_r, m1_mycr_r;
  logic signed [39:0]             m1_ssp_r, m1_csr_r;
  logic signed [15:0]             m1_mx_r, m1_mz_r;
  logic signed [tch_pkg::HW-1:0]  m2_hx_r, m2_t1_r, m2_t2_r, m2_mycr_r;
  logic signed [tch_pkg::HW-1:0]  m3_hx_r, m3_hy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_mxcp_r <= rd_side[N].mx * cpx[N];
      m1_mzsp_r <= rd_side[N].mz * cpy[N];
      m1_mycr_r <= rd_side[N].my * crx[N];
      m1_ssp_r  <= cry[N] * cpy[N];
      m1_csr_r  <= cpx[N] * cry[N];
      m1_mx_r   <= rd_side[N].mx;
      m1_mz_r   <= rd_side[N].mz;

      m2_hx_r   <= (tch_pkg::HW'(m1_mxcp_r) + tch_pkg::HW'(m1_mzsp_r)) <<< 16;
      m2_t1_r   <= m1_mx_r * m1_ssp_r;
      m2_t2_r   <= m1_mz_r * m1_csr_r;
      m2_mycr_r <= tch_pkg::HW'(m1_mycr_r) <<< 16;

      m3_hx_r   <= m2_hx_r;
      m3_hy_r   <= m2_mycr_r + m2_t1_r - m2_t2_r;
    end
  end

  // left half plane turned by a quarter circle first, hy of zero counts positive
  logic signed [tch_pkg::AW-1:0] hx_e, hy_e;
  logic signed [tch_pkg::AW-1:0] hx0 [0:N];
  logic signed [tch_pkg::AW-1:0] hy0 [0:N];
  logic signed [tch_pkg::ZW-1:0] hz0 [0:N];
  logic                          hzero [0:N];

  assign hx_e = tch_pkg::AW'(m3_hx_r);
  assign hy_e = tch_pkg::AW'(m3_hy_r);

  always_comb begin
    if (hx_e < 0) begin
      if (hy_e >= 0) begin
        hx0[0] = hy_e;
        hy0[0] = -hx_e;
        hz0[0] = tch_pkg::HalfPi;
      end else begin
        hx0[0] = -hy_e;
        hy0[0] = hx_e;
        hz0[0] = -tch_pkg::HalfPi;
      end
    end else begin
      hx0[0] = hx_e;
      hy0[0] = hy_e;
      hz0[0] = '0;
    end
  end

  assign hzero[0] = (m3_hx_r == '0) && (m3_hy_r == '0);

  for (genvar k = 0; k < N; k++) begin : g_head
    tch_vec_cell #(.W(tch_pkg::AW), .SH(k)) u_head (
      .clk(clk), .en(adv),
      .x_i(hx0[k]), .y_i(hy0[k]), .z_i(hz0[k]),
      .x_o(hx0[k+1]), .y_o(hy0[k+1]), .z_o(hz0[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        hzero[k+1] <= hzero[k];
      end
    end
  end

  // radians q16 to hundredths of a degree, halves away from zero, saturated
  logic [tch_pkg::ZW-1:0]    cv_mag;
  logic [tch_pkg::ProdW-1:0] cv_prod_r;
  logic                      cv_neg_r, cv_zero_r;
  logic [tch_pkg::ProdW:0]   cv_round;
  logic [17:0]               cv_p, cv_sat;
  logic signed [15:0]        heading_nxt, heading_r;

  assign cv_mag = (hz0[N] < 0) ? unsigned'(-hz0[N]) : unsigned'(hz0[N]);

  always_ff @(posedge clk) begin
    if (adv) begin
      cv_prod_r <= tch_pkg::ProdW'(cv_mag * tch_pkg::Deg100PerRad);
      cv_neg_r  <= hz0[N] < 0;
      cv_zero_r <= hzero[N];
    end
  end

  assign cv_round = {1'b0, cv_prod_r} + (tch_pkg::ProdW+1)'(64'h8000_0000);
  assign cv_p     = cv_round[tch_pkg::ProdW:32];
  assign cv_sat   = (cv_p > tch_pkg::MaxDeg100) ? tch_pkg::MaxDeg100 : cv_p;

  always_comb begin
    if (cv_zero_r) begin
      heading_nxt = '0;
    end else if (cv_neg_r) begin
      heading_nxt = -signed'(cv_sat[15:0]);
    end else begin
      heading_nxt = signed'(cv_sat[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      heading_r <= heading_nxt;
    end
  end

  assign out_heading = heading_r;

  // result always within the atan2 range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading >= -16'sd18000) && (out_heading <= 16'sd18000))
    else $error("heading out of range");

  // a held result freezes every stage's valid bit
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

  // a positive angle never yields a negative heading
  a_sign_pos: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !cv_neg_r |=> out_heading >= 16'sd0)
    else $error("heading sign flipped");

  // zero horizontal field gives heading zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    adv && cv_zero_r |=> out_heading == 16'sd0)
    else $error("zero field not reported as zero");

endmodule

@@ verif/tb_tilt_compensated_heading.sv @@
// testbench for the tilt-compensated heading pipeline
`timescale 1ns / 1ps

module tb_tilt_compensated_heading;

  localparam int Stages    = 16;
  localparam int NumStages = (Stages > 24) ? 24 : Stages;
  localparam int Latency   = 36 + 3 * NumStages;
  localparam int NumRandom = 1930;

  // arctangent of 2^-i in q16 radians, own copy for prediction
  localparam longint AtanTab[24] = '{
    51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0
  };
  localparam longint UnitStart = 39797;      // 2^16 / cordic gain
  localparam longint QuarterTurn = 102944;   // pi/2 in q16
  localparam longint RadToDeg100 = 375493621;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] in_accel_x, in_accel_y, in_accel_z;
  logic signed [15:0] in_mag_x, in_mag_y, in_mag_z;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] out_heading;

  int mismatches;
  int requests_sent;
  int headings_seen;
  bit accept_stall_phase;

  tilt_compensated_heading #(.CORDIC_STAGES(Stages)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_accel_z(in_accel_z),
    .in_mag_x(in_mag_x), .in_mag_y(in_mag_y), .in_mag_z(in_mag_z),
    .out_valid(out_valid), .out_stall(out_stall), .out_heading(out_heading)
  );

  // floor shift, matches an arithmetic right shift on a negative value
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // integer square root of a 64-bit unsigned value
  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring cordic, angle of (x, y) with x >= 0
  function automatic longint angle_of(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < NumStages; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y < 0) begin
        x -= ys; y += xs; z -= AtanTab[i];
      end else begin
        x += ys; y -= xs; z += AtanTab[i];
      end
    end
    return z;
  endfunction

  // rotation cordic giving cos and sin in q16
  function automatic void cos_sin(input longint z, output longint c, output longint s);
    longint x, y, xs, ys;
    x = UnitStart;
    y = 0;
    for (int i = 0; i < NumStages; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= AtanTab[i];
      end else begin
        x += ys; y -= xs; z += AtanTab[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic logic signed [15:0] predict_heading(
    input logic signed [15:0] ax16, ay16, az16, mx16, my16, mz16);
    longint ax, ay, az, mx, my, mz;
    longint pitch, roll, cp, sp, cr, sr, hx, hy, z;
    longint unsigned mag, p;
    ax = ax16; ay = ay16; az = az16;
    mx = mx16; my = my16; mz = mz16;
    pitch = angle_of(int_sqrt(longint'(ay * ay + az * az) << 28), ax * 16384);
    roll  = angle_of(int_sqrt(longint'(ax * ax + az * az) << 28), ay * 16384);
    cos_sin(pitch, cp, sp);
    cos_sin(roll, cr, sr);
    hx = mx * cp * 65536 + mz * sp * 65536;
    hy = my * cr * 65536 + mx * (sr * sp) - mz * (cp * sr);
    if (hx == 0 && hy == 0) return '0;
    // left half plane is turned a quarter first, hy of zero counts positive
    if (hx < 0) begin
      if (hy >= 0) z = QuarterTurn + angle_of(hy, -hx);
      else z = -QuarterTurn + angle_of(-hy, hx);
    end else begin
      z = angle_of(hx, hy);
    end
    mag = (z < 0) ? longint'(-z) : longint'(z);
    p = (mag * longint'(RadToDeg100) + (64'd1 << 31)) >> 32;
    if (p > 18000) p = 18000;
    return (z < 0) ? -16'(p) : 16'(p);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  // scoreboard holding the predicted headings in request order
  class heading_board;
    logic signed [15:0] pending[$];

    function void note_request(logic signed [15:0] ax, ay, az, mx, my, mz);
      pending.push_back(predict_heading(ax, ay, az, mx, my, mz));
    endfunction

    task check_heading(logic signed [15:0] got);
      logic signed [15:0] want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("heading %0d with nothing pending", got));
        return;
      end
      want = pending.pop_front();
      if (got !== want)
        report_mismatch($sformatf("heading got %0d want %0d", got, want));
    endtask
  endclass

  heading_board board;

  initial begin
    clk = 0;
  end
  always #5 clk = ~clk;

  // monitor: every accepted request and result, sampled at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        board.note_request(in_accel_x, in_accel_y, in_accel_z,
                           in_mag_x, in_mag_y, in_mag_z);
        requests_sent++;
      end
      if (out_valid && !out_stall) begin
        board.check_heading(out_heading);
        headings_seen++;
      end
    end
  end

  // receiver stalls: per result a random wait, sometimes none for a stretch
  initial begin
    int wait_n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      wait_n = accept_stall_phase ? $urandom_range(0, 6) : 0;
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // send one request, valid is held until accepted
  task automatic send_request(input logic signed [15:0] ax, ay, az, mx, my, mz,
                              input bit idle_gaps);
    int gap;
    gap = idle_gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_accel_x <= ax; in_accel_y <= ay; in_accel_z <= az;
    in_mag_x   <= mx; in_mag_y   <= my; in_mag_z   <= mz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
  endtask

  // random axis value, often near the extremes or zero
  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return 16'(int'($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [15:0] ext[4];
    board = new();
    mismatches = 0;
    requests_sent = 0;
    headings_seen = 0;
    accept_stall_phase = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_accel_x <= '0; in_accel_y <= '0; in_accel_z <= '0;
    in_mag_x <= '0; in_mag_y <= '0; in_mag_z <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero tilt, zero field, extremes, each quadrant, negative x axis
    send_request(0, 0, 0, 0, 0, 0, 0);
    send_request(0, 0, 16384, 0, 0, 0, 0);
    send_request(0, 0, 0, 1000, 0, 0, 0);
    send_request(0, 0, 16384, -1000, 0, 0, 0);        // atan2(0, negative)
    send_request(0, 0, 16384, -1000, 1, 0, 0);
    send_request(0, 0, 16384, -1000, -1, 0, 0);
    send_request(0, 0, 16384, 0, 1000, 0, 0);
    send_request(0, 0, 16384, 0, -1000, 0, 0);
    send_request(0, 0, 16384, 700, 700, 0, 0);
    send_request(0, 0, 16384, -700, -700, 300, 0);
    ext = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
    for (int i = 0; i < 4; i++)
      send_request(ext[i], ext[i], ext[i], ext[i], ext[i], ext[i], 0);
    send_request(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 0);
    send_request(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 0);
    send_request(16'sh8000, 0, 0, 123, -456, 789, 0);
    send_request(0, 16'sh8000, 0, -123, 456, -789, 0);
    send_request(16'sh7FFF, 16'sh7FFF, 0, 5000, 5000, 5000, 0);
    go_idle();

    // pressure: hold the sender until the pipeline drains
    while (board.pending.size() != 0) @(posedge clk);
    accept_stall_phase = 1'b1;

    for (int n = 0; n < NumRandom; n++) begin
      // back-to-back stretch with no idling from one third of the way to halfway
      bit gaps;
      gaps = !(n > NumRandom / 3 && n < NumRandom / 2);
      if (n == NumRandom / 2) begin
        go_idle();
        while (board.pending.size() != 0) @(posedge clk);
      end
      send_request(pick_axis(), pick_axis(), pick_axis(),
                   pick_axis(), pick_axis(), pick_axis(), gaps);
    end
    go_idle();

    while (board.pending.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);

    $display("covered %0d requests and %0d headings, zero tilt and zero field cases,",
             requests_sent, headings_seen);
    $display("axis extremes and random stalls on both channels");
    if (mismatches == 0 && board.pending.size() == 0)
      $display("tilt_compensated_heading test passed");
    else
      $display("tilt_compensated_heading test failed");
    $finish;
  end

  // hard limit well beyond the slowest legal run
  initial begin
    #3000000;
    $display("timeout with %0d headings pending", board.pending.size());
    $display("tilt_compensated_heading test failed");
    $finish;
  end

endmodule
